[src/irpfd_pkg.sv]
package irpfd_pkg;

    localparam int FRAME_BYTES = 4;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int BIT_CNT_W   = $clog2(FRAME_BITS);
    localparam int TICK_W      = 16;
    localparam int CFG_W       = 16;
    localparam int REG_IDX_W   = 3;
    localparam int BYTE_W      = 8;
    localparam int OUT_BYTES   = 4;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_DONE  = 2'd2,
        ST_ERROR = 2'd3
    } t_status;

    localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW_MIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW_MAX  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_HIGH_MIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_HIGH_MAX = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BURST_MIN       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BURST_MAX       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE_MIN   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE_MAX   = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0] leader_low_min;
        logic [CFG_W-1:0] leader_low_max;
        logic [CFG_W-1:0] leader_high_min;
        logic [CFG_W-1:0] leader_high_max;
        logic [CFG_W-1:0] burst_min;
        logic [CFG_W-1:0] burst_max;
        logic [CFG_W-1:0] one_space_min;
        logic [CFG_W-1:0] one_space_max;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        leader_low_min:  16'd23500,
        leader_low_max:  16'd26265,
        leader_high_min: 16'd11059,
        leader_high_max: 16'd13824,
        burst_min:       16'd940,
        burst_max:       16'd2157,
        one_space_min:   16'd4037,
        one_space_max:   16'd5253
    };

    typedef struct packed {
        logic level;
        logic lead_low_ok;
        logic lead_high_ok;
        logic burst_ok;
        logic zero_ok;
        logic one_ok;
    } t_cls;

    typedef struct packed {
        t_status                          status;
        logic [OUT_BYTES-1:0][BYTE_W-1:0] code;
    } t_result;

endpackage

[src/ir_pulse_frame_decoder_core.sv]
// Infrared pulse frame decoder for NEC-style remote control frames.
// Each input transaction carries one measured line interval: its level
// (i_line_level) and its length in timer ticks (i_interval_ticks). An input
// transaction completes on a rising edge with push high and full low.
// Every input transaction yields exactly one result transaction: a status
// (idle, frame in progress, frame complete, error) and the four code bytes
// as they stand after that interval. A result waits on the output ports
// while empty is low and is taken on an edge with pop high.
// The front classifies each interval against the timing windows and puts
// it into a two-entry queue; the back runs the frame state machine and
// writes its results into a two-entry result queue. The block takes one
// interval per cycle as long as results are popped at the same rate.
// When pop stays low, both queues fill and full rises after four pending
// transactions. The user must write timing windows through i_cfg_we,
// i_cfg_addr and i_cfg_wdata only while the block is idle; the block
// itself does not enforce this. Synchronous reset loads the default
// windows, clears the code bytes and empties both queues.
module ir_pulse_frame_decoder_core
    import irpfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_line_level,
    input  logic [TICK_W-1:0]    i_interval_ticks,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_status,
    output logic [BYTE_W-1:0]    o_code_byte0,
    output logic [BYTE_W-1:0]    o_code_byte1,
    output logic [BYTE_W-1:0]    o_code_byte2,
    output logic [BYTE_W-1:0]    o_code_byte3
);

    logic    w_cls_valid;
    t_cls    w_cls;
    logic    w_cls_take;
    t_result w_result;

    irpfd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .push             (push),
        .full             (full),
        .i_line_level     (i_line_level),
        .i_interval_ticks (i_interval_ticks),
        .o_cls_valid      (w_cls_valid),
        .o_cls            (w_cls),
        .i_cls_take       (w_cls_take)
    );

    irpfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (w_cls_valid),
        .i_cls       (w_cls),
        .o_cls_take  (w_cls_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (w_result)
    );

    assign o_status     = w_result.status;
    assign o_code_byte0 = w_result.code[0];
    assign o_code_byte1 = w_result.code[1];
    assign o_code_byte2 = w_result.code[2];
    assign o_code_byte3 = w_result.code[3];

endmodule

[src/irpfd_front.sv]
module irpfd_front
    import irpfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_line_level,
    input  logic [TICK_W-1:0]    i_interval_ticks,
    output logic                 o_cls_valid,
    output t_cls                 o_cls,
    input  logic                 i_cls_take
);

    t_cfg       r_cfg;
    t_cls       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cls       n_cls;
    logic       w_push_ok;

    always_comb begin
        n_cls.level        = i_line_level;
        n_cls.lead_low_ok  = (i_interval_ticks >= r_cfg.leader_low_min) &&
                             (i_interval_ticks <= r_cfg.leader_low_max);
        n_cls.lead_high_ok = (i_interval_ticks >= r_cfg.leader_high_min) &&
                             (i_interval_ticks <= r_cfg.leader_high_max);
        n_cls.burst_ok     = (i_interval_ticks >= r_cfg.burst_min) &&
                             (i_interval_ticks <= r_cfg.burst_max);
        n_cls.zero_ok      = (i_interval_ticks > r_cfg.burst_min) &&
                             (i_interval_ticks < r_cfg.burst_max);
        n_cls.one_ok       = (i_interval_ticks > r_cfg.one_space_min) &&
                             (i_interval_ticks < r_cfg.one_space_max);
    end

    assign full        = (r_count == 2'd2);
    assign w_push_ok   = push && !full;
    assign o_cls_valid = (r_count != 2'd0);
    assign o_cls       = r_q[r_rd_ptr];
    assign n_count     = r_count + {1'b0, w_push_ok} - {1'b0, i_cls_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_RESET;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_LEADER_LOW_MIN:  r_cfg.leader_low_min  <= i_cfg_wdata;
                    REG_LEADER_LOW_MAX:  r_cfg.leader_low_max  <= i_cfg_wdata;
                    REG_LEADER_HIGH_MIN: r_cfg.leader_high_min <= i_cfg_wdata;
                    REG_LEADER_HIGH_MAX: r_cfg.leader_high_max <= i_cfg_wdata;
                    REG_BURST_MIN:       r_cfg.burst_min       <= i_cfg_wdata;
                    REG_BURST_MAX:       r_cfg.burst_max       <= i_cfg_wdata;
                    REG_ONE_SPACE_MIN:   r_cfg.one_space_min   <= i_cfg_wdata;
                    REG_ONE_SPACE_MAX:   r_cfg.one_space_max   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cls_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr_ptr] <= n_cls;
        end
    end

    a_take_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cls_take |-> o_cls_valid)
        else $error("Classified item taken from an empty queue.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("Classified queue count out of range.");

endmodule

[src/irpfd_back.sv]
module irpfd_back
    import irpfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cls_valid,
    input  t_cls                 i_cls,
    output logic                 o_cls_take,
    output logic                 empty,
    input  logic                 pop,
    output t_result              o_result
);

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_LEAD_HIGH = 4'b0010,
        S_BURST     = 4'b0100,
        S_SPACE     = 4'b1000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [BIT_CNT_W-1:0]  n_bit_cnt;
    logic [BYTE_W-1:0]     r_shift;
    logic [BYTE_W-1:0]     n_shift;
    logic [BYTE_W-1:0]     r_store [FRAME_BYTES];
    logic [BYTE_W-1:0]     n_store [FRAME_BYTES];
    t_status               n_status;
    t_result               n_result;
    t_result               r_oq [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_ocount;
    logic [1:0]            n_ocount;
    logic                  w_pop_ok;
    logic                  w_room;
    logic [BIT_CNT_W-1:0]  w_byte_idx;

    assign w_pop_ok   = pop && !empty;
    assign w_room     = (r_ocount != 2'd2) || w_pop_ok;
    assign o_cls_take = i_cls_valid && w_room;
    assign w_byte_idx = r_bit_cnt >> 3;

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_status  = ST_BUSY;
        for (int j = 0; j < FRAME_BYTES; j++) begin
            n_store[j] = r_store[j];
        end
        case (r_state)
            S_IDLE: begin
                if (i_cls.level) begin
                    n_status = ST_IDLE;
                end else if (i_cls.lead_low_ok) begin
                    n_state = S_LEAD_HIGH;
                end else begin
                    n_status = ST_ERROR;
                end
            end
            S_LEAD_HIGH: begin
                if (i_cls.level && i_cls.lead_high_ok) begin
                    n_state   = S_BURST;
                    n_bit_cnt = '0;
                end else begin
                    n_status = ST_ERROR;
                    n_state  = S_IDLE;
                end
            end
            S_BURST: begin
                if (!i_cls.level && i_cls.burst_ok) begin
                    n_state = S_SPACE;
                end else begin
                    n_status = ST_ERROR;
                    n_state  = S_IDLE;
                end
            end
            S_SPACE: begin
                if (i_cls.level && (i_cls.zero_ok || i_cls.one_ok)) begin
                    n_shift = {~i_cls.zero_ok, r_shift[BYTE_W-1:1]};
                    if (r_bit_cnt[2:0] == 3'd7) begin
                        for (int j = 0; j < FRAME_BYTES; j++) begin
                            if (w_byte_idx == BIT_CNT_W'(j)) begin
                                n_store[j] = n_shift;
                            end
                        end
                    end
                    if (r_bit_cnt == LAST_BIT) begin
                        n_status = ST_DONE;
                        n_state  = S_IDLE;
                    end else begin
                        n_state   = S_BURST;
                        n_bit_cnt = r_bit_cnt + BIT_CNT_W'(1);
                    end
                end else begin
                    n_status = ST_ERROR;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_status = ST_ERROR;
                n_state  = S_IDLE;
            end
        endcase
    end

    assign n_result.status = n_status;

    for (genvar g = 0; g < OUT_BYTES; g++) begin : g_code
        if (g < FRAME_BYTES) begin : g_used
            assign n_result.code[g] = n_store[g];
        end else begin : g_unused
            assign n_result.code[g] = '0;
        end
    end

    assign empty    = (r_ocount == 2'd0);
    assign o_result = r_oq[r_rd_ptr];
    assign n_ocount = r_ocount + {1'b0, o_cls_take} - {1'b0, w_pop_ok};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            for (int j = 0; j < FRAME_BYTES; j++) begin
                r_store[j] <= '0;
            end
            r_wr_ptr  <= 1'b0;
            r_rd_ptr  <= 1'b0;
            r_ocount  <= 2'd0;
        end else begin
            if (o_cls_take) begin
                r_state   <= n_state;
                r_bit_cnt <= n_bit_cnt;
                r_shift   <= n_shift;
                for (int j = 0; j < FRAME_BYTES; j++) begin
                    r_store[j] <= n_store[j];
                end
                r_wr_ptr  <= ~r_wr_ptr;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_ocount <= n_ocount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_take) begin
            r_oq[r_wr_ptr] <= n_result;
        end
    end

    a_bit_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= LAST_BIT)
        else $error("Bit counter ran past the last frame bit.");

    a_done_on_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cls_take && (n_status == ST_DONE)) |-> ((r_state == S_SPACE) &&
        (r_bit_cnt == LAST_BIT)))
        else $error("Frame completed before its last bit.");

    a_ocount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocount <= 2'd2)
        else $error("Result queue count out of range.");

endmodule

[tb/sv/tb_ir_pulse_frame_decoder_core.sv]
module tb_ir_pulse_frame_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import irpfd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 14;
    localparam int FRAME_ITEMS = 2 + 2 * FRAME_BITS;

    typedef enum logic [1:0] {
        HUNT_LEADER,
        LEADER_SPACE,
        DATA_BURST,
        DATA_SPACE
    } t_decode_state;

    typedef struct packed {
        logic              level;
        logic [TICK_W-1:0] ticks;
    } t_interval;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 i_line_level = 1'b0;
    logic [TICK_W-1:0]    i_interval_ticks = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [1:0]           o_status;
    logic [BYTE_W-1:0]    o_code_byte0;
    logic [BYTE_W-1:0]    o_code_byte1;
    logic [BYTE_W-1:0]    o_code_byte2;
    logic [BYTE_W-1:0]    o_code_byte3;

    ir_pulse_frame_decoder_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .push             (push),
        .full             (full),
        .i_line_level     (i_line_level),
        .i_interval_ticks (i_interval_ticks),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_code_byte0     (o_code_byte0),
        .o_code_byte1     (o_code_byte1),
        .o_code_byte2     (o_code_byte2),
        .o_code_byte3     (o_code_byte3)
    );

    t_interval     pending_intervals[$];
    t_result       expected_results[$];
    t_interval     next_interval;
    t_cfg          win = CFG_RESET;
    t_decode_state dec_state = HUNT_LEADER;
    int            bit_idx = 0;
    logic [7:0]    shift_byte = '0;
    logic [7:0]    code_store[FRAME_BYTES] = '{default: '0};
    int            queued_items = 0;
    int            accepted_items = 0;
    int            results_seen = 0;
    int            mismatches = 0;
    int            rx_hold = 0;
    int            stall_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit in_span(logic [15:0] t, logic [15:0] lo, logic [15:0] hi);
        return t >= lo && t <= hi;
    endfunction

    function automatic bit strictly_inside(logic [15:0] t, logic [15:0] lo, logic [15:0] hi);
        return t > lo && t < hi;
    endfunction

    task automatic decode_interval(input logic level, input logic [TICK_W-1:0] ticks);
        t_result r;
        logic    bit_value;
        bit      space_ok;
        r.status = ST_BUSY;
        case (dec_state)
            HUNT_LEADER: begin
                if (level) begin
                    r.status = ST_IDLE;
                end else if (in_span(ticks, win.leader_low_min, win.leader_low_max)) begin
                    dec_state = LEADER_SPACE;
                end else begin
                    r.status = ST_ERROR;
                end
            end
            LEADER_SPACE: begin
                if (level && in_span(ticks, win.leader_high_min, win.leader_high_max)) begin
                    dec_state = DATA_BURST;
                    bit_idx = 0;
                end else begin
                    r.status = ST_ERROR;
                    dec_state = HUNT_LEADER;
                end
            end
            DATA_BURST: begin
                if (!level && in_span(ticks, win.burst_min, win.burst_max)) begin
                    dec_state = DATA_SPACE;
                end else begin
                    r.status = ST_ERROR;
                    dec_state = HUNT_LEADER;
                end
            end
            default: begin
                space_ok = 1'b1;
                bit_value = 1'b0;
                if (!level) begin
                    space_ok = 1'b0;
                end else if (strictly_inside(ticks, win.burst_min, win.burst_max)) begin
                    bit_value = 1'b0;
                end else if (strictly_inside(ticks, win.one_space_min, win.one_space_max)) begin
                    bit_value = 1'b1;
                end else begin
                    space_ok = 1'b0;
                end
                if (!space_ok) begin
                    r.status = ST_ERROR;
                    dec_state = HUNT_LEADER;
                end else begin
                    shift_byte = {bit_value, shift_byte[7:1]};
                    if (bit_idx % 8 == 7) begin
                        code_store[bit_idx / 8] = shift_byte;
                    end
                    if (bit_idx == FRAME_BITS - 1) begin
                        r.status = ST_DONE;
                        dec_state = HUNT_LEADER;
                    end else begin
                        bit_idx++;
                        dec_state = DATA_BURST;
                    end
                end
            end
        endcase
        for (int j = 0; j < OUT_BYTES; j++) begin
            r.code[j] = (j < FRAME_BYTES) ? code_store[j] : '0;
        end
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                decode_interval(i_line_level, i_interval_ticks);
                accepted_items++;
            end
            if (!push || !full) begin
                if (pending_intervals.size() > 0 &&
                    ((accepted_items >= 150 && accepted_items < 230) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    next_interval = pending_intervals.pop_front();
                    push <= 1'b1;
                    i_line_level <= next_interval.level;
                    i_interval_ticks <= next_interval.ticks;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transaction with none expected, status %0d",
                             $time, o_status);
                end else begin
                    check_field("status", 8'(expected_results[0].status), 8'(o_status));
                    check_field("code_byte0", expected_results[0].code[0], o_code_byte0);
                    check_field("code_byte1", expected_results[0].code[1], o_code_byte1);
                    check_field("code_byte2", expected_results[0].code[2], o_code_byte2);
                    check_field("code_byte3", expected_results[0].code[3], o_code_byte3);
                    void'(expected_results.pop_front());
                end
                results_seen++;
                if (results_seen == 60) begin
                    rx_hold = 64;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else begin
                pop <= (results_seen >= 150 && results_seen < 230) ||
                       $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (i_rst_n && stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_interval(input logic level, input int ticks);
        t_interval it;
        it.level = level;
        it.ticks = TICK_W'(ticks);
        pending_intervals.push_back(it);
        queued_items++;
    endtask

    function automatic logic [15:0] pick_span(logic [15:0] lo, logic [15:0] hi);
        int r;
        r = $urandom_range(7);
        if (lo > hi) return 16'($urandom_range(65535));
        if (r == 0) return lo;
        if (r == 1) return hi;
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] pick_inside(logic [15:0] lo, logic [15:0] hi);
        int r;
        r = $urandom_range(7);
        if (int'(hi) - int'(lo) < 2) return 16'($urandom_range(65535));
        if (r == 0) return lo + 16'd1;
        if (r == 1) return hi - 16'd1;
        return 16'($urandom_range(hi - 1, lo + 1));
    endfunction

    // A frame is cut short at break_at: that interval gets the wrong level
    // when flip is set, or a random length otherwise.
    task automatic queue_frame(input logic [FRAME_BITS-1:0] code, input int break_at,
                               input bit flip);
        logic        lvl;
        logic [15:0] t;
        for (int i = 0; i < FRAME_ITEMS; i++) begin
            if (i == 0) begin
                lvl = 1'b0;
                t = pick_span(win.leader_low_min, win.leader_low_max);
            end else if (i == 1) begin
                lvl = 1'b1;
                t = pick_span(win.leader_high_min, win.leader_high_max);
            end else if (i % 2 == 0) begin
                lvl = 1'b0;
                t = pick_span(win.burst_min, win.burst_max);
            end else begin
                lvl = 1'b1;
                t = code[(i - 3) / 2] ? pick_inside(win.one_space_min, win.one_space_max)
                                      : pick_inside(win.burst_min, win.burst_max);
            end
            if (i == break_at) begin
                if (flip) begin
                    lvl = ~lvl;
                end else begin
                    t = 16'($urandom_range(65535));
                end
                queue_interval(lvl, t);
                return;
            end
            queue_interval(lvl, t);
        end
    endtask

    task automatic queue_random_traffic(input int count);
        int goal;
        int pick;
        goal = queued_items + count;
        while (queued_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                queue_frame($urandom(), -1, 1'b0);
            end else if (pick < 85) begin
                queue_frame($urandom(), $urandom_range(FRAME_ITEMS - 1), $urandom_range(1));
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    case ($urandom_range(3))
                        0: queue_interval($urandom_range(1), 0);
                        1: queue_interval($urandom_range(1), 65535);
                        default: queue_interval($urandom_range(1), $urandom_range(65535));
                    endcase
                end
            end
        end
    endtask

    task automatic write_window(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        case (idx)
            REG_LEADER_LOW_MIN:  win.leader_low_min = value;
            REG_LEADER_LOW_MAX:  win.leader_low_max = value;
            REG_LEADER_HIGH_MIN: win.leader_high_min = value;
            REG_LEADER_HIGH_MAX: win.leader_high_max = value;
            REG_BURST_MIN:       win.burst_min = value;
            REG_BURST_MAX:       win.burst_max = value;
            REG_ONE_SPACE_MIN:   win.one_space_min = value;
            REG_ONE_SPACE_MAX:   win.one_space_max = value;
            default: ;
        endcase
    endtask

    task automatic load_windows(input int ll_lo, input int ll_hi, input int lh_lo,
                                input int lh_hi, input int b_lo, input int b_hi,
                                input int o_lo, input int o_hi);
        write_window(REG_LEADER_LOW_MIN, CFG_W'(ll_lo));
        write_window(REG_LEADER_LOW_MAX, CFG_W'(ll_hi));
        write_window(REG_LEADER_HIGH_MIN, CFG_W'(lh_lo));
        write_window(REG_LEADER_HIGH_MAX, CFG_W'(lh_hi));
        write_window(REG_BURST_MIN, CFG_W'(b_lo));
        write_window(REG_BURST_MAX, CFG_W'(b_hi));
        write_window(REG_ONE_SPACE_MIN, CFG_W'(o_lo));
        write_window(REG_ONE_SPACE_MAX, CFG_W'(o_hi));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // The test waits here until every queued interval is sent and every expected result has come back.
    task automatic wait_quiet();
        while (pending_intervals.size() > 0 || push || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_interval(1'b1, 0);
        queue_interval(1'b1, 65535);
        queue_interval(1'b0, 65535);
        queue_interval(1'b0, 23499);
        queue_interval(1'b0, 26266);
        queue_interval(1'b0, 23500);
        queue_interval(1'b0, 12000);
        queue_interval(1'b0, 26265);
        queue_interval(1'b1, 11058);
        queue_interval(1'b0, 23500);
        queue_interval(1'b1, 13824);
        queue_interval(1'b1, 1000);
        queue_interval(1'b0, 23500);
        queue_interval(1'b1, 11059);
        queue_interval(1'b0, 939);
        queue_interval(1'b0, 24000);
        queue_interval(1'b1, 12000);
        queue_interval(1'b0, 2157);
        queue_interval(1'b0, 1500);
        queue_interval(1'b0, 24000);
        queue_interval(1'b1, 12000);
        queue_interval(1'b0, 940);
        queue_interval(1'b1, 4037);

        queue_interval(1'b0, 23500);
        queue_interval(1'b1, 13824);
        for (int b = 0; b < FRAME_BITS; b++) begin
            queue_interval(1'b0, b[0] ? 2157 : 940);
            if ((32'h3DC27F80 >> b) & 1) begin
                queue_interval(1'b1, b[1] ? 5252 : 4038);
            end else begin
                queue_interval(1'b1, b[1] ? 2156 : 941);
            end
        end
        queue_frame(32'h55AA0FF0, 2 + 2 * 20, 1'b1);
        queue_random_traffic(30);
        wait_quiet();

        load_windows(100, 200, 50, 80, 10, 20, 30, 40);
        queue_random_traffic(20);
        wait_quiet();

        // Zero and one space windows overlap here, so a space in both is a zero.
        load_windows(100, 200, 50, 80, 10, 50, 30, 70);
        queue_interval(1'b0, 150);
        queue_interval(1'b1, 60);
        queue_interval(1'b0, 30);
        queue_interval(1'b1, 40);
        queue_interval(1'b0, 10);
        queue_interval(1'b1, 60);
        queue_interval(1'b0, 50);
        queue_interval(1'b1, 50);
        queue_interval(1'b0, 51);
        queue_random_traffic(20);
        wait_quiet();

        load_windows(0, 65535, 0, 65535, 0, 65535, 0, 65535);
        queue_random_traffic(10);
        wait_quiet();

        load_windows(65535, 0, 65535, 0, 65535, 0, 65535, 0);
        queue_random_traffic(10);
        wait_quiet();

        load_windows(CFG_RESET.leader_low_min, CFG_RESET.leader_low_max,
                     CFG_RESET.leader_high_min, CFG_RESET.leader_high_max,
                     CFG_RESET.burst_min, CFG_RESET.burst_max,
                     CFG_RESET.one_space_min, CFG_RESET.one_space_max);
        queue_random_traffic(30);
        wait_quiet();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
src/irpfd_pkg.sv
src/irpfd_front.sv
src/irpfd_back.sv
src/ir_pulse_frame_decoder_core.sv
tb/sv/tb_ir_pulse_frame_decoder_core.sv
